// File: rtl/sine_cosine_table_interp_core_assert.svh
// assertion macros used by the checker in scti_checker.sv
`ifndef SINE_COSINE_TABLE_INTERP_CORE_ASSERT_SVH
`define SINE_COSINE_TABLE_INTERP_CORE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define SCTI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// delayed implication, consequent checked later than the antecedent
`define SCTI_ASSERT_IMP3(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##3 (cons)) \
        else $error("%m: delayed check failed");

`endif

// File: rtl/scti_pkg.sv
// types, constants and quarter-wave table for the sine/cosine core
package scti_pkg;

    localparam int IDX_W  = 15;
    localparam int SEL_W  = 8;
    localparam int FRAC_W = 6;
    localparam int OUT_W  = 17;
    localparam int DIFF_W = 8;
    localparam int PROD_W = DIFF_W + FRAC_W;

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(16'h0020);
    localparam logic [OUT_W-1:0]  MAG_ONE    = 17'h08000;

    // per-lane control word carried beside the table read
    typedef struct packed {
        logic [FRAC_W-1:0] frac;
        logic              full;
        logic              neg;
    } lane_ctl_t;

    // first-quadrant sine, 0x8000 is one
    localparam logic [15:0] QROM [257] = '{
        16'h0000, 16'h00C9, 16'h0192, 16'h025B, 16'h0324, 16'h03ED, 16'h04B6, 16'h057F,
        16'h0648, 16'h0711, 16'h07D9, 16'h08A2, 16'h096B, 16'h0A33, 16'h0AFB, 16'h0BC4,
        16'h0C8C, 16'h0D54, 16'h0E1C, 16'h0EE4, 16'h0FAB, 16'h1073, 16'h113A, 16'h1201,
        16'h12C8, 16'h138F, 16'h1455, 16'h151C, 16'h15E2, 16'h16A8, 16'h176E, 16'h1833,
        16'h18F9, 16'h19BE, 16'h1A83, 16'h1B47, 16'h1C0C, 16'h1CD0, 16'h1D93, 16'h1E57,
        16'h1F1A, 16'h1FDD, 16'h209F, 16'h2162, 16'h2224, 16'h22E5, 16'h23A7, 16'h2467,
        16'h2528, 16'h25E8, 16'h26A8, 16'h2768, 16'h2827, 16'h28E5, 16'h29A4, 16'h2A62,
        16'h2B1F, 16'h2BDC, 16'h2C99, 16'h2D55, 16'h2E11, 16'h2ECC, 16'h2F87, 16'h3042,
        16'h30FC, 16'h31B5, 16'h326E, 16'h3327, 16'h33DF, 16'h3497, 16'h354E, 16'h3604,
        16'h36BA, 16'h3770, 16'h3825, 16'h38D9, 16'h398D, 16'h3A40, 16'h3AF3, 16'h3BA5,
        16'h3C57, 16'h3D08, 16'h3DB8, 16'h3E68, 16'h3F17, 16'h3FC6, 16'h4074, 16'h4121,
        16'h41CE, 16'h427A, 16'h4326, 16'h43D1, 16'h447B, 16'h4524, 16'h45CD, 16'h4675,
        16'h471D, 16'h47C4, 16'h486A, 16'h490F, 16'h49B4, 16'h4A58, 16'h4AFB, 16'h4B9E,
        16'h4C40, 16'h4CE1, 16'h4D81, 16'h4E21, 16'h4EC0, 16'h4F5E, 16'h4FFB, 16'h5098,
        16'h5134, 16'h51CF, 16'h5269, 16'h5303, 16'h539B, 16'h5433, 16'h54CA, 16'h5560,
        16'h55F6, 16'h568A, 16'h571E, 16'h57B1, 16'h5843, 16'h58D4, 16'h5964, 16'h59F4,
        16'h5A82, 16'h5B10, 16'h5B9D, 16'h5C29, 16'h5CB4, 16'h5D3E, 16'h5DC8, 16'h5E50,
        16'h5ED7, 16'h5F5E, 16'h5FE4, 16'h6068, 16'h60EC, 16'h616F, 16'h61F1, 16'h6272,
        16'h62F2, 16'h6371, 16'h63EF, 16'h646C, 16'h64E9, 16'h6564, 16'h65DE, 16'h6657,
        16'h66D0, 16'h6747, 16'h67BD, 16'h6832, 16'h68A7, 16'h691A, 16'h698C, 16'h69FD,
        16'h6A6E, 16'h6ADD, 16'h6B4B, 16'h6BB8, 16'h6C24, 16'h6C8F, 16'h6CF9, 16'h6D62,
        16'h6DCA, 16'h6E31, 16'h6E97, 16'h6EFB, 16'h6F5F, 16'h6FC2, 16'h7023, 16'h7083,
        16'h70E3, 16'h7141, 16'h719E, 16'h71FA, 16'h7255, 16'h72AF, 16'h7308, 16'h735F,
        16'h73B6, 16'h740B, 16'h7460, 16'h74B3, 16'h7505, 16'h7556, 16'h75A6, 16'h75F4,
        16'h7642, 16'h768E, 16'h76D9, 16'h7723, 16'h776C, 16'h77B4, 16'h77FB, 16'h7840,
        16'h7885, 16'h78C8, 16'h790A, 16'h794A, 16'h798A, 16'h79C9, 16'h7A06, 16'h7A42,
        16'h7A7D, 16'h7AB7, 16'h7AEF, 16'h7B27, 16'h7B5D, 16'h7B92, 16'h7BC6, 16'h7BF9,
        16'h7C2A, 16'h7C5A, 16'h7C89, 16'h7CB7, 16'h7CE4, 16'h7D0F, 16'h7D3A, 16'h7D63,
        16'h7D8A, 16'h7DB1, 16'h7DD6, 16'h7DFB, 16'h7E1E, 16'h7E3F, 16'h7E60, 16'h7E7F,
        16'h7E9D, 16'h7EBA, 16'h7ED6, 16'h7EF0, 16'h7F0A, 16'h7F22, 16'h7F38, 16'h7F4E,
        16'h7F62, 16'h7F75, 16'h7F87, 16'h7F98, 16'h7FA7, 16'h7FB5, 16'h7FC2, 16'h7FCE,
        16'h7FD9, 16'h7FE2, 16'h7FEA, 16'h7FF1, 16'h7FF6, 16'h7FFA, 16'h7FFE, 16'h7FFF,
        16'h8000
    };

endpackage

// File: rtl/sine_cosine_table_interp_core.sv
// Sine and cosine of a 16-bit phase by quarter-wave table and linear interpolation.
//
// Input: drive phase and pulse start; a word is taken on every edge where start
// is high and busy is low. busy stays low, so a new phase may enter each cycle.
// Output: done is high for exactly one cycle with sine_value and cosine_value
// (17-bit two's complement, 0x8000 is one). The receiver cannot stall, so the
// result must be captured in that cycle.
// Pipeline: done rises together with the output register, which follows the rom
// register and the product register (fold and rom address, rom read and multiply,
// round/add/sign into the output register).
// Throughput: one word per cycle; the dual-port rom gives both lanes one read
// each cycle, each read returning the entry and its upper neighbor.
// Reset: rst_n clears the valid pipeline, so no done appears until a word
// has been accepted after reset.
module sine_cosine_table_interp_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [15:0]                       phase,
    output logic                              done,
    output logic signed [scti_pkg::OUT_W-1:0] sine_value,
    output logic signed [scti_pkg::OUT_W-1:0] cosine_value
);
    import scti_pkg::*;

    logic [16:0]    p_ext;
    logic [16:0]    s_wide;
    logic [16:0]    c_wide;
    logic [IDX_W-1:0] s_idx;
    logic [IDX_W-1:0] c_idx;
    logic           s_neg;
    logic           c_neg;
    lane_ctl_t      s_ctl_reg;
    lane_ctl_t      c_ctl_reg;
    logic [31:0]    s_pair;
    logic [31:0]    c_pair;
    logic           v1_reg;
    logic           v2_reg;
    logic           done_reg;
    logic           accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign p_ext  = {1'b0, phase};

    // quadrant fold into first-quadrant indexes and signs
    always_comb
    begin
        case (phase[15:14])
            2'd0:
            begin
                s_wide = p_ext;
                c_wide = 17'h04000 - p_ext;
                s_neg  = 1'b0;
                c_neg  = 1'b0;
            end
            2'd1:
            begin
                s_wide = 17'h08000 - p_ext;
                c_wide = p_ext - 17'h04000;
                s_neg  = 1'b0;
                c_neg  = 1'b1;
            end
            2'd2:
            begin
                s_wide = p_ext - 17'h08000;
                c_wide = 17'h0C000 - p_ext;
                s_neg  = 1'b1;
                c_neg  = 1'b1;
            end
            default:
            begin
                s_wide = 17'h10000 - p_ext;
                c_wide = p_ext - 17'h0C000;
                s_neg  = 1'b1;
                c_neg  = 1'b0;
            end
        endcase
        s_idx = s_wide[IDX_W-1:0];
        c_idx = c_wide[IDX_W-1:0];
    end

    // table read, one port per lane
    scti_rom u_rom (
        .clk    (clk),
        .addr_a (s_idx[IDX_W-2:FRAC_W]),
        .addr_b (c_idx[IDX_W-2:FRAC_W]),
        .pair_a (s_pair),
        .pair_b (c_pair)
    );

    // lane control travels alongside the rom read
    always_ff @(posedge clk)
    begin
        s_ctl_reg <= '{frac: s_idx[FRAC_W-1:0], full: s_idx[IDX_W-1], neg: s_neg};
        c_ctl_reg <= '{frac: c_idx[FRAC_W-1:0], full: c_idx[IDX_W-1], neg: c_neg};
    end

    scti_interp u_sine (
        .clk   (clk),
        .pair  (s_pair),
        .ctl   (s_ctl_reg),
        .value (sine_value)
    );

    scti_interp u_cosine (
        .clk   (clk),
        .pair  (c_pair),
        .ctl   (c_ctl_reg),
        .value (cosine_value)
    );

    // valid pipeline for the done strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    assign done = done_reg;

endmodule

// File: rtl/scti_rom.sv
// dual-port synchronous quarter-wave rom returning adjacent entry pairs
module scti_rom (
    input  logic                       clk,
    input  logic [scti_pkg::SEL_W-1:0] addr_a,
    input  logic [scti_pkg::SEL_W-1:0] addr_b,
    output logic [31:0]                pair_a,
    output logic [31:0]                pair_b
);
    import scti_pkg::*;

    logic [31:0]    pair_a_reg;
    logic [31:0]    pair_b_reg;
    logic [SEL_W:0] next_a;
    logic [SEL_W:0] next_b;

    // address of the entry above the selected one
    assign next_a = {1'b0, addr_a} + (SEL_W+1)'(1);
    assign next_b = {1'b0, addr_b} + (SEL_W+1)'(1);

    // registered read, upper entry in the high half
    always_ff @(posedge clk)
    begin
        pair_a_reg <= {QROM[next_a], QROM[{1'b0, addr_a}]};
        pair_b_reg <= {QROM[next_b], QROM[{1'b0, addr_b}]};
    end

    assign pair_a = pair_a_reg;
    assign pair_b = pair_b_reg;

endmodule

// File: rtl/scti_interp.sv
// interpolation and sign stage for one lane
module scti_interp (
    input  logic                              clk,
    input  logic [31:0]                       pair,
    input  scti_pkg::lane_ctl_t               ctl,
    output logic signed [scti_pkg::OUT_W-1:0] value
);
    import scti_pkg::*;

    logic [15:0]        lo;
    logic [15:0]        hi;
    logic [15:0]        diff_full;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  prod_reg;
    logic [15:0]        lo_reg;
    logic               full_reg;
    logic               neg_reg;
    logic [PROD_W:0]    rounded;
    logic [OUT_W-1:0]   mag;
    logic [OUT_W-1:0]   value_next;
    logic [OUT_W-1:0]   value_reg;

    assign lo        = pair[15:0];
    assign hi        = pair[31:16];
    assign diff_full = hi - lo;

    // slope times fraction, table steps are under 256
    assign prod = PROD_W'(diff_full[DIFF_W-1:0]) * PROD_W'(ctl.frac);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        lo_reg   <= lo;
        full_reg <= ctl.full;
        neg_reg  <= ctl.neg;
    end

    // round, add base entry, apply quadrant sign
    always_comb
    begin
        rounded = {1'b0, prod_reg} + {1'b0, ROUND_HALF};
        if (full_reg)
            mag = MAG_ONE;
        else
            mag = {1'b0, lo_reg} + OUT_W'(rounded[PROD_W:FRAC_W]);
        value_next = neg_reg ? (OUT_W'(0) - mag) : mag;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// File: rtl/scti_checker.sv
// port-level checker for the sine/cosine core and its bind
`include "sine_cosine_table_interp_core_assert.svh"

module scti_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic [15:0]                       phase,
    input logic                              done,
    input logic signed [scti_pkg::OUT_W-1:0] sine_value,
    input logic signed [scti_pkg::OUT_W-1:0] cosine_value
);
    import scti_pkg::*;

    logic sine_in_range;
    logic cosine_in_range;
    logic unit_pair;

    // range and zero-phase terms
    assign sine_in_range   = (sine_value <= 17'sh08000) && (sine_value >= -17'sh08000);
    assign cosine_in_range = (cosine_value <= 17'sh08000) && (cosine_value >= -17'sh08000);
    assign unit_pair       = (sine_value == 17'sh00000) && (cosine_value == 17'sh08000);

    // every accepted word is followed by a result
    `SCTI_ASSERT_IMP3(a_word_done, start && !busy, done)

    // no result without an accepted word
    `SCTI_ASSERT_IMP(a_no_spurious, done, $past(start && !busy, 3))

    // results stay within plus and minus one
    `SCTI_ASSERT_IMP(a_range, done, sine_in_range && cosine_in_range)

    // zero phase gives exact zero sine and unit cosine
    `SCTI_ASSERT_IMP(a_zero_phase, done && ($past(phase, 3) == 16'h0000), unit_pair)

endmodule

bind sine_cosine_table_interp_core scti_checker u_scti_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .phase        (phase),
    .done         (done),
    .sine_value   (sine_value),
    .cosine_value (cosine_value)
);

// File: tb/sine_cosine_table_interp_core_tb.sv
// testbench for the sine/cosine quarter-wave table core: directed and random phases
`timescale 1ns / 100ps

module sine_cosine_table_interp_core_tb;

    import scti_pkg::*;

    localparam logic [16:0] QUARTER_TURN = 17'h04000;
    localparam logic [16:0] HALF_TURN    = 17'h08000;
    localparam logic [16:0] THREE_QUARTER = 17'h0C000;
    localparam logic [16:0] FULL_TURN    = 17'h10000;
    localparam int          RANDOM_WORDS = 1300;
    localparam int          DRAIN_LIMIT  = 1000;

    typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quadrant_e;

    // one sine/cosine pair as the core returns it
    typedef struct packed {
        logic [15:0]      phase;
        logic [OUT_W-1:0] sine;
        logic [OUT_W-1:0] cosine;
    } trig_pair_t;

    // directed row: pinned marks a pair typed in by hand
    typedef struct packed {
        logic [15:0]      phase;
        logic             pinned;
        logic [OUT_W-1:0] sine;
        logic [OUT_W-1:0] cosine;
    } phase_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [15:0] phase = 16'h0000;
    logic busy;
    logic done;
    logic signed [OUT_W-1:0] sine_value;
    logic signed [OUT_W-1:0] cosine_value;

    trig_pair_t pending_pairs[$];
    int mismatch_count = 0;
    bit idle_on = 1'b0;

    sine_cosine_table_interp_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .phase        (phase),
        .done         (done),
        .sine_value   (sine_value),
        .cosine_value (cosine_value)
    );

    // 50 MHz clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // hard stop in case the core hangs
    initial
    begin
        #2000000;
        $display("** sine_cosine_table_interp_core: FAILED **");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // first-quadrant magnitude for a folded index 0..0x4000
    function automatic logic [OUT_W-1:0] quarter_mag(input logic [16:0] idx);
        int sel;
        int frac;
        int lo;
        int hi;
        if (idx >= QUARTER_TURN)
            return MAG_ONE;
        sel  = int'(idx) >> FRAC_W;
        frac = int'(idx) & ((1 << FRAC_W) - 1);
        lo   = int'(QROM[sel]);
        if (frac == 0)
            return OUT_W'(lo);
        hi = int'(QROM[sel + 1]);
        return OUT_W'(lo + (((hi - lo) * frac + 32) >> FRAC_W));
    endfunction

    function automatic logic [OUT_W-1:0] apply_sign(input logic [OUT_W-1:0] mag, input bit neg);
        return neg ? OUT_W'(-mag) : mag;
    endfunction

    // sine and cosine of a phase by quadrant folding
    function automatic trig_pair_t predict_trig(input logic [15:0] ph);
        trig_pair_t r;
        logic [16:0] p;
        p = {1'b0, ph};
        r.phase = ph;
        case (quadrant_e'(ph[15:14]))
            QUAD_I:
            begin
                r.sine   = apply_sign(quarter_mag(p), 1'b0);
                r.cosine = apply_sign(quarter_mag(QUARTER_TURN - p), 1'b0);
            end
            QUAD_II:
            begin
                r.sine   = apply_sign(quarter_mag(HALF_TURN - p), 1'b0);
                r.cosine = apply_sign(quarter_mag(p - QUARTER_TURN), 1'b1);
            end
            QUAD_III:
            begin
                r.sine   = apply_sign(quarter_mag(p - HALF_TURN), 1'b1);
                r.cosine = apply_sign(quarter_mag(THREE_QUARTER - p), 1'b1);
            end
            default:
            begin
                r.sine   = apply_sign(quarter_mag(FULL_TURN - p), 1'b1);
                r.cosine = apply_sign(quarter_mag(p - THREE_QUARTER), 1'b0);
            end
        endcase
        return r;
    endfunction

    // present one word, hold it until taken, then queue its expected pair
    task automatic send_phase(input trig_pair_t want);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        phase <= want.phase;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_pairs.push_back(want);
    endtask

    // random phase, biased toward quadrant edges and whole table entries
    function automatic logic [15:0] random_phase();
        case ($urandom_range(0, 7))
            0: return 16'({$urandom_range(0, 3), 14'h0000} + $urandom_range(0, 4) - 2);
            1: return 16'($urandom_range(0, 16'hFFFF) & 16'hFFC0);
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // result checker, done is sampled at the edge that ends its cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_pairs.size() == 0)
                report_mismatch($sformatf("unexpected word sine=%h cosine=%h",
                                          sine_value, cosine_value));
            else
            begin
                trig_pair_t want;
                want = pending_pairs.pop_front();
                if (sine_value !== want.sine)
                    report_mismatch($sformatf("phase %h sine got %h want %h",
                                              want.phase, sine_value, want.sine));
                if (cosine_value !== want.cosine)
                    report_mismatch($sformatf("phase %h cosine got %h want %h",
                                              want.phase, cosine_value, want.cosine));
            end
        end
    end

    // stimulus
    initial
    begin
        phase_row_t directed_rows [18];
        trig_pair_t want;
        int w;

        // quadrant edges, extremes, exact quarter turns and zero fractions
        directed_rows = '{
            '{16'h0000, 1'b1, 17'h00000, 17'h08000},
            '{16'h4000, 1'b1, 17'h08000, 17'h00000},
            '{16'h8000, 1'b1, 17'h00000, 17'h18000},
            '{16'hC000, 1'b1, 17'h18000, 17'h00000},
            '{16'hFFFF, 1'b1, 17'h1FFFD, 17'h08000},
            '{16'h0001, 1'b1, 17'h00003, 17'h08000},
            '{16'h0040, 1'b1, 17'h000C9, 17'h07FFF},
            '{16'h3FFF, 1'b0, 17'h00000, 17'h00000},
            '{16'h4001, 1'b0, 17'h00000, 17'h00000},
            '{16'h7FFF, 1'b0, 17'h00000, 17'h00000},
            '{16'h8001, 1'b0, 17'h00000, 17'h00000},
            '{16'hBFFF, 1'b0, 17'h00000, 17'h00000},
            '{16'hC001, 1'b0, 17'h00000, 17'h00000},
            '{16'h2000, 1'b0, 17'h00000, 17'h00000},
            '{16'h003F, 1'b0, 17'h00000, 17'h00000},
            '{16'h0020, 1'b0, 17'h00000, 17'h00000},
            '{16'h5555, 1'b0, 17'h00000, 17'h00000},
            '{16'hAAAA, 1'b0, 17'h00000, 17'h00000}
        };

        // reset
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words, back to back
        idle_on = 1'b0;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].pinned)
                want = '{directed_rows[i].phase, directed_rows[i].sine,
                         directed_rows[i].cosine};
            else
                want = predict_trig(directed_rows[i].phase);
            send_phase(want);
        end

        // random words, idling switched on and off in stretches
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 64 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            send_phase(predict_trig(random_phase()));
        end
        start <= 1'b0;

        // drain the pipeline
        for (w = 0; w < DRAIN_LIMIT && pending_pairs.size() > 0; w++)
            @(posedge clk);
        repeat (6) @(posedge clk);
        if (pending_pairs.size() > 0)
            report_mismatch($sformatf("%0d words never returned", pending_pairs.size()));

        if (mismatch_count == 0)
            $display("** sine_cosine_table_interp_core: PASSED **");
        else
            $display("** sine_cosine_table_interp_core: FAILED **");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/scti_pkg.sv
rtl/scti_rom.sv
rtl/scti_interp.sv
rtl/sine_cosine_table_interp_core.sv
rtl/scti_checker.sv
tb/sine_cosine_table_interp_core_tb.sv
